>>> rtl/core/fast_float_square_root_unit_defines.svh
// Assertion macros shared by the square root unit.
`ifndef FAST_FLOAT_SQUARE_ROOT_UNIT_DEFINES_SVH
`define FAST_FLOAT_SQUARE_ROOT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFSR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ffsr: same-cycle check failed");
`define FFSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ffsr: next-cycle check failed");
`else
`define FFSR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FFSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/core/ffsr_pkg.sv
package ffsr_pkg;

    typedef logic [31:0] t_f32;

    localparam t_f32 MAGIC_SEED  = 32'h5f37_59df;
    localparam t_f32 ONE_HALF    = 32'h3f00_0000;
    localparam t_f32 THREE_HALF  = 32'h3fc0_0000;
    localparam t_f32 DEFAULT_NAN = 32'hffc0_0000;
    localparam logic [30:0] INF_MAG = 31'h7f80_0000;

    localparam int MUL_LAT     = 3;
    localparam int SUB_LAT     = 3;
    localparam int DIV_STAGES  = 9;
    localparam int RCP_LAT     = DIV_STAGES + 2;
    localparam int NEWTON_LAT  = 3 * MUL_LAT + SUB_LAT;
    localparam int FFSR_LATENCY = MUL_LAT + 3 * NEWTON_LAT + RCP_LAT;

    function automatic logic f_is_nan(input t_f32 v);
        return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
    endfunction

    function automatic t_f32 f_quiet(input t_f32 v);
        return v | 32'h0040_0000;
    endfunction

    function automatic logic [5:0] f_lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] f_lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    // Rounds a significand whose leading one sits at bit 47 to nearest even
    // and packs it with the biased exponent, going subnormal or to infinity where needed.
    function automatic t_f32 f_round_pack(input logic s, input logic signed [11:0] be,
                                          input logic [47:0] m);
        logic [11:0] sh;
        logic [47:0] ms;
        logic [47:0] back;
        logic        lost;
        logic [7:0]  ef;
        logic [30:0] word;
        logic        g;
        logic        st;
        logic        inc;
        ms   = m;
        lost = 1'b0;
        ef   = be[7:0];
        back = '0;
        sh   = '0;
        if (be > 12'sd254) begin
            return {s, INF_MAG};
        end
        if (be < 12'sd1) begin
            sh = 12'(12'sd1 - be);
            ef = 8'd0;
            if (sh > 12'd47) begin
                ms   = '0;
                lost = |m;
            end else begin
                ms   = m >> sh[5:0];
                back = ms << sh[5:0];
                lost = (back != m);
            end
        end
        word = {ef, ms[46:24]};
        g    = ms[23];
        st   = (|ms[22:0]) | lost;
        inc  = g & (st | word[0]);
        return {s, word + 31'(inc)};
    endfunction

endpackage

>>> rtl/core/ffsr_delay.sv
module ffsr_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];
endmodule

>>> rtl/core/ffsr_fmul.sv
module ffsr_fmul
    import ffsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_f32 i_a,
    input  t_f32 i_b,
    output t_f32 o_res
);
    // Stage one: classify and multiply significands.
    logic               n_spec;
    t_f32               n_spec_v;
    logic [7:0]         w_ea;
    logic [7:0]         w_eb;
    logic [23:0]        w_sa;
    logic [23:0]        w_sb;
    logic               w_sign;
    logic               w_a_inf;
    logic               w_b_inf;
    logic               r1_spec;
    t_f32               r1_spec_v;
    logic               r1_sign;
    logic signed [11:0] r1_exp;
    logic [47:0]        r1_prod;

    assign w_ea    = (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23];
    assign w_eb    = (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23];
    assign w_sa    = {i_a[30:23] != 8'd0, i_a[22:0]};
    assign w_sb    = {i_b[30:23] != 8'd0, i_b[22:0]};
    assign w_sign  = i_a[31] ^ i_b[31];
    assign w_a_inf = (i_a[30:0] == INF_MAG);
    assign w_b_inf = (i_b[30:0] == INF_MAG);

    always_comb begin
        n_spec   = 1'b1;
        n_spec_v = {w_sign, 31'd0};
        if (f_is_nan(i_a)) begin
            n_spec_v = f_quiet(i_a);
        end else if (f_is_nan(i_b)) begin
            n_spec_v = f_quiet(i_b);
        end else if ((w_a_inf && i_b[30:0] == 31'd0) || (w_b_inf && i_a[30:0] == 31'd0)) begin
            n_spec_v = DEFAULT_NAN;
        end else if (w_a_inf || w_b_inf) begin
            n_spec_v = {w_sign, INF_MAG};
        end else if (i_a[30:0] == 31'd0 || i_b[30:0] == 31'd0) begin
            n_spec_v = {w_sign, 31'd0};
        end else begin
            n_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_spec   <= n_spec;
            r1_spec_v <= n_spec_v;
            r1_sign   <= w_sign;
            r1_exp    <= 12'(w_ea) + 12'(w_eb) - 12'd126;
            r1_prod   <= w_sa * w_sb;
        end
    end

    // Stage two: normalise the product.
    logic [5:0]         w_lz;
    logic               r2_spec;
    t_f32               r2_spec_v;
    logic               r2_sign;
    logic signed [11:0] r2_exp;
    logic [47:0]        r2_norm;

    assign w_lz = f_lzc48(r1_prod);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_spec   <= r1_spec;
            r2_spec_v <= r1_spec_v;
            r2_sign   <= r1_sign;
            r2_exp    <= r1_exp - 12'(w_lz);
            r2_norm   <= r1_prod << w_lz;
        end
    end

    // Stage three: round and pack.
    t_f32 r3_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res <= r2_spec ? r2_spec_v : f_round_pack(r2_sign, r2_exp, r2_norm);
        end
    end

    assign o_res = r3_res;
endmodule

>>> rtl/core/ffsr_fsub.sv
module ffsr_fsub
    import ffsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_f32 i_a,
    input  t_f32 i_b,
    output t_f32 o_res
);
    // Stage one: order by magnitude and align the smaller operand.
    logic        w_sbn;
    logic        w_swap;
    t_f32        w_big;
    t_f32        w_sml;
    logic        w_big_s;
    logic        w_sml_s;
    logic [7:0]  w_eb;
    logic [7:0]  w_es;
    logic [7:0]  w_d;
    logic [26:0] w_ext;
    logic [26:0] w_shf;
    logic [26:0] w_al;
    logic        n_spec;
    t_f32        n_spec_v;

    assign w_sbn   = ~i_b[31];
    assign w_swap  = i_b[30:0] > i_a[30:0];
    assign w_big   = w_swap ? i_b : i_a;
    assign w_sml   = w_swap ? i_a : i_b;
    assign w_big_s = w_swap ? w_sbn : i_a[31];
    assign w_sml_s = w_swap ? i_a[31] : w_sbn;
    assign w_eb    = (w_big[30:23] == 8'd0) ? 8'd1 : w_big[30:23];
    assign w_es    = (w_sml[30:23] == 8'd0) ? 8'd1 : w_sml[30:23];
    assign w_d     = w_eb - w_es;
    assign w_ext   = {w_sml[30:23] != 8'd0, w_sml[22:0], 3'b000};

    always_comb begin
        w_shf = '0;
        if (w_d > 8'd27) begin
            w_al = {26'd0, |w_ext};
        end else begin
            w_shf = w_ext >> w_d[4:0];
            w_al  = {w_shf[26:1], w_shf[0] | ((w_shf << w_d[4:0]) != w_ext)};
        end
    end

    always_comb begin
        n_spec   = 1'b1;
        n_spec_v = DEFAULT_NAN;
        if (f_is_nan(i_a)) begin
            n_spec_v = f_quiet(i_a);
        end else if (f_is_nan(i_b)) begin
            n_spec_v = f_quiet(i_b);
        end else if (i_a[30:0] == INF_MAG && i_b[30:0] == INF_MAG) begin
            n_spec_v = (i_a[31] == w_sbn) ? i_a : DEFAULT_NAN;
        end else if (i_a[30:0] == INF_MAG) begin
            n_spec_v = i_a;
        end else if (i_b[30:0] == INF_MAG) begin
            n_spec_v = {w_sbn, INF_MAG};
        end else begin
            n_spec = 1'b0;
        end
    end

    logic        r1_spec;
    t_f32        r1_spec_v;
    logic        r1_sign;
    logic        r1_zsign;
    logic        r1_diff;
    logic [7:0]  r1_exp;
    logic [26:0] r1_big;
    logic [26:0] r1_sml;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_spec   <= n_spec;
            r1_spec_v <= n_spec_v;
            r1_sign   <= w_big_s;
            r1_zsign  <= i_a[31] & w_sbn;
            r1_diff   <= w_big_s ^ w_sml_s;
            r1_exp    <= w_eb;
            r1_big    <= {w_big[30:23] != 8'd0, w_big[22:0], 3'b000};
            r1_sml    <= w_al;
        end
    end

    // Stage two: add or subtract and normalise.
    logic [27:0]        w_sum;
    logic [47:0]        w_m;
    logic [5:0]         w_lz;
    logic               r2_spec;
    t_f32               r2_spec_v;
    logic               r2_sign;
    logic signed [11:0] r2_exp;
    logic [47:0]        r2_norm;

    assign w_sum = r1_diff ? ({1'b0, r1_big} - {1'b0, r1_sml})
                           : ({1'b0, r1_big} + {1'b0, r1_sml});
    assign w_m   = {w_sum, 20'd0};
    assign w_lz  = f_lzc48(w_m);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_spec   <= r1_spec || (w_sum == 28'd0);
            r2_spec_v <= r1_spec ? r1_spec_v : {r1_zsign, 31'd0};
            r2_sign   <= r1_sign;
            r2_exp    <= 12'(r1_exp) + 12'd1 - 12'(w_lz);
            r2_norm   <= w_m << w_lz;
        end
    end

    // Stage three: round and pack.
    t_f32 r3_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res <= r2_spec ? r2_spec_v : f_round_pack(r2_sign, r2_exp, r2_norm);
        end
    end

    assign o_res = r3_res;
endmodule

>>> rtl/core/ffsr_frcp.sv
module ffsr_frcp
    import ffsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_f32 i_y,
    output t_f32 o_res
);
    // Entry stage: classify and normalise the divisor.
    logic [23:0] w_sig;
    logic [7:0]  w_e;
    logic [4:0]  w_lz;
    logic        n_spec;
    t_f32        n_spec_v;

    assign w_sig = {i_y[30:23] != 8'd0, i_y[22:0]};
    assign w_e   = (i_y[30:23] == 8'd0) ? 8'd1 : i_y[30:23];
    assign w_lz  = f_lzc24(w_sig);

    always_comb begin
        n_spec   = 1'b1;
        n_spec_v = {i_y[31], INF_MAG};
        if (f_is_nan(i_y)) begin
            n_spec_v = f_quiet(i_y);
        end else if (i_y[30:0] == INF_MAG) begin
            n_spec_v = {i_y[31], 31'd0};
        end else if (i_y[30:0] == 31'd0) begin
            n_spec_v = {i_y[31], INF_MAG};
        end else begin
            n_spec = 1'b0;
        end
    end

    logic               r_spec   [DIV_STAGES+1];
    t_f32               r_spec_v [DIV_STAGES+1];
    logic               r_sign   [DIV_STAGES+1];
    logic signed [11:0] r_exp    [DIV_STAGES+1];
    logic [23:0]        r_den    [DIV_STAGES+1];
    logic [24:0]        r_rem    [DIV_STAGES+1];
    logic [26:0]        r_quo    [DIV_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec[0]   <= n_spec;
            r_spec_v[0] <= n_spec_v;
            r_sign[0]   <= i_y[31];
            r_exp[0]    <= 12'(w_e) - 12'(w_lz);
            r_den[0]    <= w_sig << w_lz;
            r_rem[0]    <= 25'h080_0000;
            r_quo[0]    <= '0;
        end
    end

    // Restoring division of 2^49 by the divisor, three quotient bits a stage.
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [24:0] w_rem;
        logic [26:0] w_quo;

        always_comb begin
            w_rem = r_rem[k];
            w_quo = r_quo[k];
            for (int j = 0; j < 3; j++) begin
                if (w_rem >= {1'b0, r_den[k]}) begin
                    w_rem = w_rem - {1'b0, r_den[k]};
                    w_quo = {w_quo[25:0], 1'b1};
                end else begin
                    w_quo = {w_quo[25:0], 1'b0};
                end
                w_rem = {w_rem[23:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_spec[k+1]   <= r_spec[k];
                r_spec_v[k+1] <= r_spec_v[k];
                r_sign[k+1]   <= r_sign[k];
                r_exp[k+1]    <= r_exp[k];
                r_den[k+1]    <= r_den[k];
                r_rem[k+1]    <= w_rem;
                r_quo[k+1]    <= w_quo;
            end
        end
    end

    // Exit stage: the quotient has its leading one at bit 26 or bit 25.
    logic [47:0]        w_m;
    logic               w_lz1;
    logic signed [11:0] w_be;
    t_f32               r_res;

    assign w_m   = {r_quo[DIV_STAGES], |r_rem[DIV_STAGES], 20'd0};
    assign w_lz1 = ~r_quo[DIV_STAGES][26];
    assign w_be  = 12'd254 - r_exp[DIV_STAGES] - 12'(w_lz1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_spec[DIV_STAGES] ? r_spec_v[DIV_STAGES]
                   : f_round_pack(r_sign[DIV_STAGES], w_be, w_lz1 ? (w_m << 1) : w_m);
        end
    end

    assign o_res = r_res;
endmodule

>>> rtl/core/ffsr_newton.sv
module ffsr_newton
    import ffsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_f32 i_y,
    input  t_f32 i_half,
    output t_f32 o_y,
    output t_f32 o_half
);
    t_f32 w_t1;
    t_f32 w_t2;
    t_f32 w_t3;
    t_f32 w_y_d3;
    t_f32 w_y_d9;

    // y' = y * (1.5 - (half * y) * y), each product rounded on its own.
    ffsr_fmul u_mul_hy (.i_clk(i_clk), .i_en(i_en), .i_a(i_half), .i_b(i_y), .o_res(w_t1));

    ffsr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_y3 (
        .i_clk(i_clk), .i_en(i_en), .i_data(i_y), .o_data(w_y_d3)
    );

    ffsr_fmul u_mul_ty (.i_clk(i_clk), .i_en(i_en), .i_a(w_t1), .i_b(w_y_d3), .o_res(w_t2));

    ffsr_fsub u_sub (.i_clk(i_clk), .i_en(i_en), .i_a(THREE_HALF), .i_b(w_t2), .o_res(w_t3));

    ffsr_delay #(.WIDTH(32), .DEPTH(MUL_LAT + SUB_LAT)) u_dly_y9 (
        .i_clk(i_clk), .i_en(i_en), .i_data(w_y_d3), .o_data(w_y_d9)
    );

    ffsr_fmul u_mul_yt (.i_clk(i_clk), .i_en(i_en), .i_a(w_y_d9), .i_b(w_t3), .o_res(o_y));

    ffsr_delay #(.WIDTH(32), .DEPTH(NEWTON_LAT)) u_dly_half (
        .i_clk(i_clk), .i_en(i_en), .i_data(i_half), .o_data(o_half)
    );
endmodule

>>> rtl/core/fast_float_square_root_unit.sv
// Approximate binary32 square root by the inverse square root method. Each item
// is one binary32 bit pattern; half of it is formed, an estimate is seeded from
// the magic constant less the pattern shifted right arithmetically by one, three
// Newton steps refine it, and the reciprocal of the estimate is returned. Every
// operation rounds to nearest even; zero, negative, subnormal, infinite and NaN
// inputs are not fixed up and give whatever the sequence yields. The unit takes
// one item per clock while it is not held and passes each through the halving
// multiply, three Newton steps (three multipliers and one subtractor of three
// stages each) and the reciprocal, whose restoring divider retires three quotient
// bits per stage. The whole pipeline advances together; it holds only when a
// result is waiting and the consumer is not ready, and then no item is lost or
// repeated.
`include "fast_float_square_root_unit_defines.svh"

module fast_float_square_root_unit
    import ffsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_root_bits
);
    // The pipeline moves whenever the output register is empty or being taken.
    logic                    w_en;
    logic [FFSR_LATENCY-1:0] r_valid;
    logic [FFSR_LATENCY-1:0] n_valid;

    assign w_en    = i_ready | ~r_valid[FFSR_LATENCY-1];
    assign o_ready = w_en;
    assign o_valid = r_valid[FFSR_LATENCY-1];
    assign n_valid = {r_valid[FFSR_LATENCY-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= n_valid;
        end
    end

    // The seed is a plain integer subtraction on the bit pattern; the sign bit
    // is copied into bit 30 by the arithmetic shift.
    t_f32 w_seed;
    t_f32 w_seed_d;
    t_f32 w_half;
    t_f32 w_y1;
    t_f32 w_h1;
    t_f32 w_y2;
    t_f32 w_h2;
    t_f32 w_y3;
    t_f32 w_h3;

    assign w_seed = MAGIC_SEED - {i_operand_bits[31], i_operand_bits[31:1]};

    ffsr_fmul u_half (
        .i_clk(i_clk), .i_en(w_en), .i_a(i_operand_bits), .i_b(ONE_HALF), .o_res(w_half)
    );

    ffsr_delay #(.WIDTH(32), .DEPTH(MUL_LAT)) u_dly_seed (
        .i_clk(i_clk), .i_en(w_en), .i_data(w_seed), .o_data(w_seed_d)
    );

    ffsr_newton u_step1 (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_seed_d), .i_half(w_half), .o_y(w_y1), .o_half(w_h1)
    );

    ffsr_newton u_step2 (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_y1), .i_half(w_h1), .o_y(w_y2), .o_half(w_h2)
    );

    // The half value is no longer needed after the last step.
    ffsr_newton u_step3 (
        .i_clk(i_clk), .i_en(w_en), .i_y(w_y2), .i_half(w_h2), .o_y(w_y3), .o_half(w_h3)
    );

    // A zero estimate gives the infinity of its own sign through the reciprocal.
    ffsr_frcp u_rcp (.i_clk(i_clk), .i_en(w_en), .i_y(w_y3), .o_res(o_root_bits));

    `FFSR_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_en, $stable(r_valid))
    `FFSR_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_valid[0])
    `FFSR_ASSERT_NEXT(a_no_invented, i_clk, i_rst_n, w_en && !r_valid[FFSR_LATENCY-2], !o_valid)
    `FFSR_ASSERT_SAME(a_wait_blocks, i_clk, i_rst_n, o_valid && !i_ready, !o_ready && (w_h3 == w_h3))
endmodule

>>> bench/fast_float_square_root_unit_tb.sv
`timescale 1ns / 100ps

module fast_float_square_root_unit_tb
    import ffsr_pkg::*;
();

    // Half clock period and the generous run limit in clock cycles.
    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 22;
    localparam t_f32 QUIET_BIT = 32'h0040_0000;
    localparam t_f32 SIGN_BIT  = 32'h8000_0000;
    localparam t_f32 INF_BITS  = 32'h7f80_0000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [31:0] i_operand_bits = '0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_root_bits;

    // Roots still owed by the unit, oldest first.
    t_f32 pending_roots[$];
    int   fail_count   = 0;
    int   cycle_count  = 0;
    // While set, neither side idles: this gives the long back-to-back stretch.
    logic steady_flow  = 1'b0;

    fast_float_square_root_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operand_bits (i_operand_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_root_bits    (o_root_bits)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Bit-exact binary32 arithmetic with round to nearest even. Values are
    // carried as a sign, the exponent of bit 63 of a 64-bit significand and
    // a sticky flag for anything shifted out below it.
    // ------------------------------------------------------------------

    function automatic logic is_nan(input t_f32 v);
        return (v[30:23] == 8'hff) && (v[22:0] != 0);
    endfunction

    function automatic logic is_inf(input t_f32 v);
        return v[30:0] == INF_BITS[30:0];
    endfunction

    function automatic logic is_zero(input t_f32 v);
        return v[30:0] == 31'd0;
    endfunction

    // A NaN operand is passed on quietened, the first operand taking precedence.
    function automatic t_f32 nan_pick(input t_f32 a, input t_f32 b);
        return is_nan(a) ? (a | QUIET_BIT) : (b | QUIET_BIT);
    endfunction

    // Splits a finite non-zero value into the exponent of its leading one and
    // a significand with that one at bit 23; subnormals are normalised here.
    function automatic void split(input t_f32 v, output int e, output logic [23:0] sig);
        if (v[30:23] != 8'd0) begin
            e   = int'(v[30:23]) - 127;
            sig = {1'b1, v[22:0]};
        end else begin
            e   = -126;
            sig = {1'b0, v[22:0]};
            while (!sig[23]) begin
                sig = sig << 1;
                e   = e - 1;
            end
        end
    endfunction

    function automatic t_f32 round_pack(input logic s, input int e, input logic [63:0] m,
                                        input logic st);
        longint      be;
        int          sh;
        logic [24:0] sig;
        logic        inc;
        longint      word;
        while (!m[63]) begin
            m = m << 1;
            e = e - 1;
        end
        be = longint'(e) + 127;
        if (be < 1) begin
            // Denormalise: the value is then an integer multiple of 2^-149.
            sh = int'(1 - be);
            if (sh >= 64) begin
                st = st | (m != 0);
                m  = '0;
            end else begin
                st = st | ((m & ((64'd1 << sh) - 1)) != 0);
                m  = m >> sh;
            end
            be = 1;
        end
        sig  = {1'b0, m[63:40]};
        st   = st | (m[38:0] != 0);
        inc  = m[39] & (st | sig[0]);
        sig  = sig + inc;
        word = ((be - 1) << 23) + longint'(sig);
        if (word >= longint'(INF_BITS)) begin
            return {s, INF_BITS[30:0]};
        end
        return {s, word[30:0]};
    endfunction

    function automatic t_f32 fp_mul(input t_f32 a, input t_f32 b);
        logic        s;
        int          ea;
        int          eb;
        logic [23:0] sa;
        logic [23:0] sb;
        logic [47:0] prod;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) begin
            return nan_pick(a, b);
        end
        if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) begin
            return DEFAULT_NAN;
        end
        if (is_inf(a) || is_inf(b)) begin
            return {s, INF_BITS[30:0]};
        end
        if (is_zero(a) || is_zero(b)) begin
            return {s, 31'd0};
        end
        split(a, ea, sa);
        split(b, eb, sb);
        prod = sa * sb;
        return round_pack(s, ea + eb + 1, {prod, 16'd0}, 1'b0);
    endfunction

    function automatic t_f32 fp_add(input t_f32 a, input t_f32 b);
        t_f32        tmp;
        int          ea;
        int          eb;
        int          d;
        logic [23:0] sa;
        logic [23:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] m;
        logic        st;
        if (is_nan(a) || is_nan(b)) begin
            return nan_pick(a, b);
        end
        if (is_inf(a) && is_inf(b)) begin
            return (a[31] == b[31]) ? a : DEFAULT_NAN;
        end
        if (is_inf(a)) begin
            return a;
        end
        if (is_inf(b)) begin
            return b;
        end
        if (is_zero(a) && is_zero(b)) begin
            return {a[31] & b[31], 31'd0};
        end
        if (is_zero(a)) begin
            return b;
        end
        if (is_zero(b)) begin
            return a;
        end
        // Keep the larger magnitude in a so that a difference stays positive.
        if (b[30:0] > a[30:0]) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        split(a, ea, sa);
        split(b, eb, sb);
        d  = ea - eb;
        ma = {25'd0, sa, 15'd0} << 24;
        mb = {25'd0, sb, 15'd0} << 24;
        if (d >= 64) begin
            st = 1'b1;
            mb = '0;
        end else begin
            st = (mb & ((64'd1 << d) - 1)) != 0;
            mb = mb >> d;
        end
        // The sticky bit sits far below the guard bit, so folding it into the
        // lowest bit keeps rounding exact.
        mb = mb | 64'(st);
        m  = (a[31] == b[31]) ? ma + mb : ma - mb;
        if (m == 0) begin
            return '0;
        end
        return round_pack(a[31], ea + 1, m, 1'b0);
    endfunction

    function automatic t_f32 fp_div(input t_f32 a, input t_f32 b);
        logic        s;
        int          ea;
        int          eb;
        logic [23:0] sa;
        logic [23:0] sb;
        logic [63:0] num;
        logic [63:0] q;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) begin
            return nan_pick(a, b);
        end
        if ((is_inf(a) && is_inf(b)) || (is_zero(a) && is_zero(b))) begin
            return DEFAULT_NAN;
        end
        if (is_inf(a) || is_zero(b)) begin
            return {s, INF_BITS[30:0]};
        end
        if (is_zero(a) || is_inf(b)) begin
            return {s, 31'd0};
        end
        split(a, ea, sa);
        split(b, eb, sb);
        num = {24'd0, sa} << 40;
        q   = num / sb;
        return round_pack(s, ea - eb, q << 23, (num % sb) != 0);
    endfunction

    // One refinement of the inverse square root estimate. A NaN product is
    // passed through the subtraction quietened with its own sign.
    function automatic t_f32 refine_estimate(input t_f32 y, input t_f32 half);
        t_f32 t;
        t = fp_mul(half, y);
        t = fp_mul(t, y);
        t = is_nan(t) ? (t | QUIET_BIT) : fp_add(THREE_HALF, t ^ SIGN_BIT);
        return fp_mul(y, t);
    endfunction

    function automatic t_f32 approx_root(input t_f32 x);
        t_f32 half;
        t_f32 y;
        half = fp_mul(x, ONE_HALF);
        // Arithmetic shift: the sign bit is copied into bit 30.
        y = MAGIC_SEED - {x[31], x[31:1]};
        for (int n = 0; n < 3; n++) begin
            y = refine_estimate(y, half);
        end
        return fp_div(32'h3f80_0000, y);
    endfunction

    // ------------------------------------------------------------------
    // Handshake side
    // ------------------------------------------------------------------

    // Offers one operand, idling beforehand at random, and records its root
    // once the unit has taken it. Valid is left high on return, so a following
    // item is presented with a single assignment in the same time step.
    task automatic send_operand(input t_f32 x);
        while (!steady_flow && ($urandom_range(99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operand_bits <= x;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_roots.push_back(approx_root(x));
    endtask

    // The consumer stalls at random except during the steady stretch.
    always @(posedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Each result taken is compared with the oldest root still owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_roots.size() == 0) begin
                $error("root_bits: unexpected item, actual %h", o_root_bits);
                fail_count++;
            end else begin
                if (o_root_bits !== pending_roots[0]) begin
                    $error("root_bits: expected %h, actual %h", pending_roots[0],
                           o_root_bits);
                    fail_count++;
                end
                void'(pending_roots.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zeros of both signs, the smallest and largest subnormals and normals,
    // infinities, quiet and signalling NaNs, negatives and the magic pattern.
    task automatic test_special_operands();
        t_f32 corner[$];
        corner = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007f_ffff,
                   32'h0080_0000, 32'h7f7f_ffff, 32'h7f80_0000, 32'hff80_0000,
                   32'h7fc0_0000, 32'h7f80_0001, 32'hffbf_ffff, 32'hffff_ffff,
                   32'h3f80_0000, 32'h4080_0000, 32'h3e80_0000, 32'hbf80_0000,
                   32'h4b00_0000, 32'h5f37_59df, 32'hbe6e_b3be, 32'h3e6e_b3be,
                   32'h8000_0001, 32'h4049_0fdb, 32'haaaa_aaaa, 32'h5555_5555};
        foreach (corner[k]) begin
            send_operand(corner[k]);
        end
    endtask

    // Mostly positive normal values, where the method is meant to be used,
    // with raw patterns and special values mixed in.
    task automatic test_random_operands(input int count);
        t_f32 x;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0, 1, 2: x = $urandom;
                3: x = {1'b0, 8'($urandom_range(254, 1)) & 8'h0f, 23'($urandom)}
                       | (($urandom_range(1)) ? 32'h0000_0000 : 32'h0000_0000);
                4: x = {$urandom_range(1) == 1, 8'hff, 23'($urandom)};
                5: x = {$urandom_range(1) == 1, 8'h00, 23'($urandom)};
                default: x = {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
            endcase
            send_operand(x);
        end
    endtask

    // Back-to-back items with the consumer always ready, to fill the pipeline.
    task automatic test_full_rate(input int count);
        steady_flow = 1'b1;
        test_random_operands(count);
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_operands();
        test_random_operands(300);
        test_full_rate(150);
        test_random_operands(200);
        i_valid <= 1'b0;
        while (pending_roots.size() != 0) begin
            @(posedge i_clk);
        end
        // Allow the pipeline depth for any stray item to appear.
        repeat (FFSR_LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/ffsr_pkg.sv
rtl/core/ffsr_delay.sv
rtl/core/ffsr_fmul.sv
rtl/core/ffsr_fsub.sv
rtl/core/ffsr_frcp.sv
rtl/core/ffsr_newton.sv
rtl/core/fast_float_square_root_unit.sv
bench/fast_float_square_root_unit_tb.sv
